// ===== design/crtq_pkg.sv =====
`default_nettype none
package crtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int RESULT_LIMIT    = 16;

  localparam logic [1:0] ACT_SET    = 2'd0;
  localparam logic [1:0] ACT_REMOVE = 2'd1;
  localparam logic [1:0] ACT_TICK   = 2'd2;

  localparam logic [1:0] KIND_SET     = 2'd0;
  localparam logic [1:0] KIND_REMOVE  = 2'd1;
  localparam logic [1:0] KIND_EXPIRED = 2'd2;

  typedef struct packed {
    logic [31:0] deadline;
    logic [31:0] key;
    logic [15:0] attempt;
  } entry_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_LE,
    ALU_EQ
  } alu_op_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        flag;
  } alu_res_t;

endpackage
`default_nettype wire

// ===== design/crtq_in_if.sv =====
`default_nettype none
interface crtq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] bundle_key;
  logic [31:0] delay;
  logic [15:0] attempt;
  logic [31:0] now_time;

  modport source (output valid, action, bundle_key, delay, attempt, now_time,
                  input ready);
  modport sink (input valid, action, bundle_key, delay, attempt, now_time,
                output ready);
endinterface
`default_nettype wire

// ===== design/crtq_out_if.sv =====
`default_nettype none
interface crtq_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        ok;
  logic [31:0] out_key;
  logic [15:0] out_attempt;
  logic        last;

  modport source (output valid, kind, ok, out_key, out_attempt, last,
                  input ready);
  modport sink (input valid, kind, ok, out_key, out_attempt, last,
                output ready);
endinterface
`default_nettype wire

// ===== design/crtq_alu.sv =====
`default_nettype none
module crtq_alu (
  input  wire crtq_pkg::alu_req_t req,
  output crtq_pkg::alu_res_t      res
);

  always_comb begin
    res.sum  = req.a + req.b;
    res.flag = 1'b0;
    case (req.op)
      crtq_pkg::ALU_ADD: res.flag = 1'b0;
      crtq_pkg::ALU_LE:  res.flag = (req.a <= req.b);
      crtq_pkg::ALU_EQ:  res.flag = (req.a == req.b);
      default:           res.flag = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/crtq_store.sv =====
`default_nettype none
module crtq_store #(
  parameter int QUEUE_DEPTH = crtq_pkg::QUEUE_DEPTH_DEF,
  localparam int AW = $clog2(QUEUE_DEPTH)
) (
  input  wire                   clk,
  input  wire                   we,
  input  wire  [AW-1:0]         waddr,
  input  wire crtq_pkg::entry_t wdata,
  input  wire                   re,
  input  wire  [AW-1:0]         raddr,
  output crtq_pkg::entry_t      rdata
);

  crtq_pkg::entry_t mem [QUEUE_DEPTH];
  crtq_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== design/custody_retransmit_timer_queue_top.sv =====
// Set moves later-deadline timers up one entry at a time until the new timer's slot is
//   found (a full table is refused); remove scans down from the top for the key, then
//   shifts the entries behind it down; tick takes expired timers from the head, up to
//   RESULT_LIMIT per tick, shifting the rest down after each one.
// Throughput: one item at a time; a new item is taken only in the idle state.
// Reset: entry count and control clear on a synchronous reset; table contents are left as they are.
`default_nettype none
module custody_retransmit_timer_queue_top #(
  parameter int QUEUE_DEPTH = crtq_pkg::QUEUE_DEPTH_DEF
) (
  input wire         clk,
  input wire         rst_n,
  crtq_in_if.sink    in_bus,
  crtq_out_if.source out_bus
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int NW = $clog2(crtq_pkg::RESULT_LIMIT + 1);

  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_SET_ADD   = 13'b0000000000010,
    ST_SET_RD    = 13'b0000000000100,
    ST_SET_CMP   = 13'b0000000001000,
    ST_REM_RD    = 13'b0000000010000,
    ST_REM_CMP   = 13'b0000000100000,
    ST_DEL_RD    = 13'b0000001000000,
    ST_DEL_WR    = 13'b0000010000000,
    ST_TICK_RD   = 13'b0000100000000,
    ST_TICK_CMP  = 13'b0001000000000,
    ST_TICK_EMIT = 13'b0010000000000,
    ST_TICK_END  = 13'b0100000000000,
    ST_ANS       = 13'b1000000000000
  } state_t;

  state_t      state_r, state_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] key_r, key_nxt;
  logic [31:0] delay_r, delay_nxt;
  logic [15:0] att_r, att_nxt;
  logic [31:0] now_r, now_nxt;
  logic [31:0] dl_r, dl_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic        pend_r, pend_nxt;
  logic [31:0] pend_key_r, pend_key_nxt;
  logic [15:0] pend_att_r, pend_att_nxt;
  logic        ok_r, ok_nxt;
  logic [31:0] res_key_r, res_key_nxt;
  logic [15:0] res_att_r, res_att_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_kind_r, out_kind_nxt;
  logic        out_ok_r, out_ok_nxt;
  logic [31:0] out_key_r, out_key_nxt;
  logic [15:0] out_att_r, out_att_nxt;
  logic        out_last_r, out_last_nxt;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  crtq_pkg::entry_t mem_wdata, rd;
  crtq_pkg::entry_t new_entry;

  crtq_pkg::alu_req_t alu_req;
  crtq_pkg::alu_res_t alu_res;

  logic          out_free, in_fire;
  logic [CW-1:0] idx_inc, idx_dec;

  crtq_store #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd)
  );

  crtq_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign out_free  = !out_valid_r || out_bus.ready;
  assign in_bus.ready = (state_r == ST_IDLE);
  assign in_fire   = in_bus.valid && in_bus.ready;
  assign idx_inc   = idx_r + CW'(1);
  assign idx_dec   = idx_r - CW'(1);
  assign new_entry = '{deadline: dl_r, key: key_r, attempt: att_r};

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    key_nxt      = key_r;
    delay_nxt    = delay_r;
    att_nxt      = att_r;
    now_nxt      = now_r;
    dl_nxt       = dl_r;
    idx_nxt      = idx_r;
    count_nxt    = count_r;
    n_nxt        = n_r;
    pend_nxt     = pend_r;
    pend_key_nxt = pend_key_r;
    pend_att_nxt = pend_att_r;
    ok_nxt       = ok_r;
    res_key_nxt  = res_key_r;
    res_att_nxt  = res_att_r;

    out_valid_nxt = out_valid_r && !out_bus.ready;
    out_kind_nxt  = out_kind_r;
    out_ok_nxt    = out_ok_r;
    out_key_nxt   = out_key_r;
    out_att_nxt   = out_att_r;
    out_last_nxt  = out_last_r;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = new_entry;
    mem_re    = 1'b0;
    mem_raddr = '0;

    alu_req.op = crtq_pkg::ALU_ADD;
    alu_req.a  = '0;
    alu_req.b  = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          op_nxt      = in_bus.action;
          key_nxt     = in_bus.bundle_key;
          delay_nxt   = in_bus.delay;
          att_nxt     = in_bus.attempt;
          now_nxt     = in_bus.now_time;
          ok_nxt      = 1'b0;
          res_key_nxt = '0;
          res_att_nxt = '0;
          idx_nxt     = count_r;
          n_nxt       = '0;
          pend_nxt    = 1'b0;
          case (in_bus.action)
            crtq_pkg::ACT_SET: begin
              state_nxt = (count_r == CW'(QUEUE_DEPTH)) ? ST_ANS : ST_SET_ADD;
            end
            crtq_pkg::ACT_REMOVE: state_nxt = ST_REM_RD;
            crtq_pkg::ACT_TICK:   state_nxt = ST_TICK_RD;
            default:              state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SET_ADD: begin
        alu_req.op = crtq_pkg::ALU_ADD;
        alu_req.a  = now_r;
        alu_req.b  = delay_r;
        dl_nxt     = alu_res.sum;
        state_nxt  = ST_SET_RD;
      end
      ST_SET_RD: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = new_entry;
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_ANS;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_nxt = ST_SET_CMP;
        end
      end
      ST_SET_CMP: begin
        // ties stay below the new timer, so older timers fire first
        alu_req.op = crtq_pkg::ALU_LE;
        alu_req.a  = rd.deadline;
        alu_req.b  = dl_r;
        mem_we     = 1'b1;
        mem_waddr  = idx_r[AW-1:0];
        if (alu_res.flag) begin
          mem_wdata = new_entry;
          count_nxt = count_r + CW'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_ANS;
        end else begin
          mem_wdata = rd;
          idx_nxt   = idx_dec;
          state_nxt = ST_SET_RD;
        end
      end
      ST_REM_RD: begin
        if (idx_r == '0) begin
          state_nxt = ST_ANS;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
          state_nxt = ST_REM_CMP;
        end
      end
      ST_REM_CMP: begin
        alu_req.op = crtq_pkg::ALU_EQ;
        alu_req.a  = rd.key;
        alu_req.b  = key_r;
        idx_nxt    = idx_dec;
        if (alu_res.flag) begin
          ok_nxt      = 1'b1;
          res_key_nxt = rd.key;
          res_att_nxt = rd.attempt;
          state_nxt   = ST_DEL_RD;
        end else begin
          state_nxt = ST_REM_RD;
        end
      end
      ST_DEL_RD: begin
        // close the gap at idx one entry at a time
        if (idx_inc < count_r) begin
          mem_re    = 1'b1;
          mem_raddr = idx_inc[AW-1:0];
          state_nxt = ST_DEL_WR;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = (op_r == crtq_pkg::ACT_REMOVE) ? ST_ANS : ST_TICK_RD;
        end
      end
      ST_DEL_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        mem_wdata = rd;
        idx_nxt   = idx_inc;
        state_nxt = ST_DEL_RD;
      end
      ST_TICK_RD: begin
        if (n_r == NW'(crtq_pkg::RESULT_LIMIT) || count_r == '0) begin
          state_nxt = ST_TICK_END;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          state_nxt = ST_TICK_CMP;
        end
      end
      ST_TICK_CMP: begin
        alu_req.op = crtq_pkg::ALU_LE;
        alu_req.a  = rd.deadline;
        alu_req.b  = now_r;
        if (!alu_res.flag) begin
          state_nxt = ST_TICK_END;
        end else if (pend_r) begin
          // another beat follows, so the held one is not the last
          state_nxt = ST_TICK_EMIT;
        end else begin
          pend_nxt     = 1'b1;
          pend_key_nxt = rd.key;
          pend_att_nxt = rd.attempt;
          n_nxt        = n_r + NW'(1);
          idx_nxt      = '0;
          state_nxt    = ST_DEL_RD;
        end
      end
      ST_TICK_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = crtq_pkg::KIND_EXPIRED;
          out_ok_nxt    = 1'b1;
          out_key_nxt   = pend_key_r;
          out_att_nxt   = pend_att_r;
          out_last_nxt  = 1'b0;
          pend_key_nxt  = rd.key;
          pend_att_nxt  = rd.attempt;
          n_nxt         = n_r + NW'(1);
          idx_nxt       = '0;
          state_nxt     = ST_DEL_RD;
        end
      end
      ST_TICK_END: begin
        if (!pend_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = crtq_pkg::KIND_EXPIRED;
          out_ok_nxt    = 1'b1;
          out_key_nxt   = pend_key_r;
          out_att_nxt   = pend_att_r;
          out_last_nxt  = 1'b1;
          pend_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_ANS: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = (op_r == crtq_pkg::ACT_SET) ? crtq_pkg::KIND_SET
                                                      : crtq_pkg::KIND_REMOVE;
          out_ok_nxt    = ok_r;
          out_key_nxt   = res_key_r;
          out_att_nxt   = res_att_r;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    delay_r    <= delay_nxt;
    att_r      <= att_nxt;
    now_r      <= now_nxt;
    dl_r       <= dl_nxt;
    idx_r      <= idx_nxt;
    pend_key_r <= pend_key_nxt;
    pend_att_r <= pend_att_nxt;
    ok_r       <= ok_nxt;
    res_key_r  <= res_key_nxt;
    res_att_r  <= res_att_nxt;
    out_kind_r <= out_kind_nxt;
    out_ok_r   <= out_ok_nxt;
    out_key_r  <= out_key_nxt;
    out_att_r  <= out_att_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_bus.valid       = out_valid_r;
  assign out_bus.kind        = out_kind_r;
  assign out_bus.ok          = out_ok_r;
  assign out_bus.out_key     = out_key_r;
  assign out_bus.out_attempt = out_att_r;
  assign out_bus.last        = out_last_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + CW'(1) || count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_emit_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK_EMIT) |-> pend_r)
    else $error("expiry beat emitted with nothing held");

  a_run_limit: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= NW'(crtq_pkg::RESULT_LIMIT))
    else $error("expiry run longer than limit");

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
`default_nettype none
module tb;

  localparam int         TABLE_DEPTH = crtq_pkg::QUEUE_DEPTH_DEF;
  localparam logic [1:0] ACT_NONE    = 2'd3;
  localparam int         TAIL_CYCLES = 600;
  localparam int         HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] key;
    logic [31:0] delay;
    logic [15:0] attempt;
    logic [31:0] now;
  } timer_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [31:0] key;
    logic [15:0] attempt;
    logic        last;
  } timer_ans_t;

  logic clk;
  logic rst_n;

  crtq_in_if  in_bus ();
  crtq_out_if out_bus ();

  custody_retransmit_timer_queue_top i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // shadow of the timer table, kept sorted by deadline
  logic [31:0] tmr_deadline [TABLE_DEPTH];
  logic [31:0] tmr_key      [TABLE_DEPTH];
  logic [15:0] tmr_attempt  [TABLE_DEPTH];
  int          tmr_count = 0;

  timer_cmd_t pending_cmds [$];
  timer_ans_t expected_answers [$];
  int         errors = 0;

  int burst_left = 1;
  int gap_left = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int hold_left = 0;
  int beats_seen = 0;

  task automatic expect_ans(input timer_ans_t a);
    expected_answers.insert(expected_answers.size(), a);
  endtask

  task automatic timer_drop(input int pos);
    int i;
    for (i = pos; i + 1 < tmr_count; i++) begin
      tmr_deadline[i] = tmr_deadline[i + 1];
      tmr_key[i]      = tmr_key[i + 1];
      tmr_attempt[i]  = tmr_attempt[i + 1];
    end
    tmr_count--;
  endtask

  task automatic timers_apply(input timer_cmd_t c);
    int          pos;
    int          i;
    int          n_due;
    logic [31:0] dl;
    case (c.action)
      crtq_pkg::ACT_SET: begin
        if (tmr_count >= TABLE_DEPTH) begin
          expect_ans({crtq_pkg::KIND_SET, 1'b0, 32'd0, 16'd0, 1'b1});
        end else begin
          dl = c.now + c.delay;
          pos = 0;
          // equal deadlines: newcomer goes behind the older ones
          while (pos < tmr_count && tmr_deadline[pos] <= dl) pos++;
          for (i = tmr_count; i > pos; i--) begin
            tmr_deadline[i] = tmr_deadline[i - 1];
            tmr_key[i]      = tmr_key[i - 1];
            tmr_attempt[i]  = tmr_attempt[i - 1];
          end
          tmr_deadline[pos] = dl;
          tmr_key[pos]      = c.key;
          tmr_attempt[pos]  = c.attempt;
          tmr_count++;
          expect_ans({crtq_pkg::KIND_SET, 1'b1, 32'd0, 16'd0, 1'b1});
        end
      end
      crtq_pkg::ACT_REMOVE: begin
        pos = -1;
        for (i = tmr_count - 1; i >= 0; i--)
          if (pos < 0 && tmr_key[i] == c.key) pos = i;
        if (pos >= 0) begin
          expect_ans({crtq_pkg::KIND_REMOVE, 1'b1, tmr_key[pos], tmr_attempt[pos], 1'b1});
          timer_drop(pos);
        end else begin
          expect_ans({crtq_pkg::KIND_REMOVE, 1'b0, 32'd0, 16'd0, 1'b1});
        end
      end
      crtq_pkg::ACT_TICK: begin
        n_due = 0;
        while (n_due < crtq_pkg::RESULT_LIMIT && n_due < tmr_count &&
               tmr_deadline[n_due] <= c.now)
          n_due++;
        for (i = 0; i < n_due; i++) begin
          expect_ans({crtq_pkg::KIND_EXPIRED, 1'b1, tmr_key[0], tmr_attempt[0],
                      i == n_due - 1});
          timer_drop(0);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_beat(input timer_ans_t got);
    timer_ans_t want;
    if (expected_answers.size() == 0) begin
      $display("%0t: result beat with nothing expected, expected none, got %h", $time, got);
      errors++;
    end else begin
      want = expected_answers.pop_front();
      check_field("kind", 32'(want.kind), 32'(got.kind));
      check_field("ok", 32'(want.ok), 32'(got.ok));
      check_field("out_key", want.key, got.key);
      check_field("out_attempt", 32'(want.attempt), 32'(got.attempt));
      check_field("last", 32'(want.last), 32'(got.last));
    end
  endtask

  task automatic queue_cmd(input logic [1:0] action, input logic [31:0] key,
                           input logic [31:0] delay, input logic [15:0] attempt,
                           input logic [31:0] now);
    timer_cmd_t c;
    c = {action, key, delay, attempt, now};
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    fork
      forever #5 clk = ~clk;
    join_none
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // sender: bursts of beats with random gaps between them
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid      <= 1'b0;
      in_bus.action     <= ACT_NONE;
      in_bus.bundle_key <= '0;
      in_bus.delay      <= '0;
      in_bus.attempt    <= '0;
      in_bus.now_time   <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        timers_apply(pending_cmds.pop_front());
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
      if (in_bus.valid && !in_bus.ready) begin
        // hold the beat until taken
      end else if (gap_left > 0) begin
        gap_left--;
        in_bus.valid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        in_bus.valid      <= 1'b1;
        in_bus.action     <= pending_cmds[0].action;
        in_bus.bundle_key <= pending_cmds[0].key;
        in_bus.delay      <= pending_cmds[0].delay;
        in_bus.attempt    <= pending_cmds[0].attempt;
        in_bus.now_time   <= pending_cmds[0].now;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes at random intervals, plus two long hold-offs
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        check_beat({out_bus.kind, out_bus.ok, out_bus.out_key, out_bus.out_attempt,
                    out_bus.last});
        beats_seen++;
        if (beats_seen == 30 || beats_seen == 150) hold_left = HOLD_CYCLES;
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_left = $urandom_range(20, 120);
      end else begin
        rx_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom_range(0, 1));
          default: out_bus.ready <= (rx_left % 4) != 0;
        endcase
      end
    end
  end

  initial begin : stimulus
    logic [31:0] key_pool [8];
    logic [31:0] gen_now;
    logic [31:0] k;
    logic [31:0] d;
    logic [31:0] t;
    int          real_items;
    int          r;
    int          i;

    // empty table: tick, unmatched remove, unknown action
    queue_cmd(crtq_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom), 32'd0);
    queue_cmd(crtq_pkg::ACT_REMOVE, 32'h1234_5678, $urandom, 16'($urandom), $urandom);
    queue_cmd(ACT_NONE, $urandom, $urandom, 16'($urandom), $urandom);
    // two equal deadlines of zero (second by wrap), then one wrapping to 4
    queue_cmd(crtq_pkg::ACT_SET, 32'hFFFF_FFFF, 32'd0, 16'hFFFF, 32'd0);
    queue_cmd(crtq_pkg::ACT_SET, 32'd0, 32'hFFFF_FFFF, 16'd0, 32'd1);
    queue_cmd(crtq_pkg::ACT_SET, 32'hA5A5_A5A5, 32'd5, 16'h1234, 32'hFFFF_FFFF);
    queue_cmd(crtq_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom), 32'd0);
    queue_cmd(crtq_pkg::ACT_REMOVE, 32'hA5A5_A5A5, $urandom, 16'($urandom), $urandom);
    // fill the table with ties and repeated keys, overflow it, then flush in one tick
    for (i = 0; i < TABLE_DEPTH + 1; i++)
      queue_cmd(crtq_pkg::ACT_SET, 32'(100 + i % 5), 32'(i % 3), 16'(i), 32'd200);
    queue_cmd(crtq_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom), 32'hFFFF_FFFF);

    for (i = 0; i < 8; i++) key_pool[i] = $urandom;
    gen_now = 32'd1000;
    real_items = 0;
    while (real_items < 280) begin
      r = $urandom_range(0, 99);
      gen_now = gen_now + $urandom_range(0, 6);
      k = ($urandom_range(0, 3) == 0) ? $urandom : key_pool[3'($urandom_range(0, 7))];
      d = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 40);
      t = ($urandom_range(0, 19) == 0) ? $urandom : gen_now;
      if (r < 4) begin
        queue_cmd(ACT_NONE, $urandom, $urandom, 16'($urandom), $urandom);
      end else begin
        if (r < 50)
          queue_cmd(crtq_pkg::ACT_SET, k, d, 16'($urandom), t);
        else if (r < 70)
          queue_cmd(crtq_pkg::ACT_REMOVE, k, $urandom, 16'($urandom), $urandom);
        else if (r < 73)
          queue_cmd(crtq_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom), 32'hFFFF_FFFF);
        else
          queue_cmd(crtq_pkg::ACT_TICK, $urandom, $urandom, 16'($urandom), t);
        real_items++;
      end
    end

    @(posedge clk);
    while (pending_cmds.size() != 0 || expected_answers.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
`default_nettype wire

// ===== custody_retransmit_timer_queue_top.f =====
design/crtq_pkg.sv
design/crtq_in_if.sv
design/crtq_out_if.sv
design/crtq_alu.sv
design/crtq_store.sv
design/custody_retransmit_timer_queue_top.sv
bench/tb.sv
